// File: rtl/core/sbc_pkg.sv
package sbc_pkg;

	localparam int NumRounds = 64;
	localparam int BlockWords = 16;
	localparam int HashWords = 8;

	typedef logic [31:0] word_t;

	localparam word_t ROUND_K [NumRounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_HV [HashWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// control from the round sequencer to the schedule memory
	typedef struct packed {
		logic       load_we;
		logic [3:0] load_addr;
		word_t      load_data;
		logic [3:0] rd_a_addr;
		logic [3:0] rd_b_addr;
		logic       step;
		logic       expand;
		logic [3:0] wr_addr;
	} sched_ctrl_t;

	function automatic word_t small_sig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic word_t big_sig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

endpackage

// File: rtl/core/sbc_sched.sv
module sbc_sched (
	input  logic               clk,
	input  sbc_pkg::sched_ctrl_t ctrl,
	output sbc_pkg::word_t     w_s1
);
	import sbc_pkg::*;

	word_t mem [BlockWords];
	word_t rd_a_q;
	word_t rd_b_q;
	word_t prev_q;
	word_t w1_q;
	word_t w2_q;
	word_t w_next;

	// prev_q: w[t-16] (or w[t] in the first sixteen rounds), rd_a_q: w[t-15],
	// rd_b_q: w[t-7], w2_q: w[t-2]
	always_comb begin
		if (ctrl.expand) begin
			w_next = prev_q + small_sig0(rd_a_q) + rd_b_q + small_sig1(w2_q);
		end else begin
			w_next = prev_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_we) begin
			mem[ctrl.load_addr] <= ctrl.load_data;
		end else if (ctrl.step && ctrl.expand) begin
			mem[ctrl.wr_addr] <= w_next;
		end
		rd_a_q <= mem[ctrl.rd_a_addr];
		rd_b_q <= mem[ctrl.rd_b_addr];
		prev_q <= rd_a_q;
		if (ctrl.step) begin
			w1_q <= w_next;
			w2_q <= w1_q;
			w_s1 <= w_next;
		end
	end

endmodule

// File: rtl/core/sha256_block_compress_core.sv
// SHA-256 compression core. Feed the padded message as big-endian 32-bit
// words, sixteen per block; set s_tuser on the first word of a message to
// reload the standard initial hash, and s_tlast on the sixteenth word of the
// final block to get the digest: eight transfers, most significant word first,
// index in m_tuser, m_tlast on the eighth. Words are taken one per cycle while
// loading; after the sixteenth word the core is busy: it primes the schedule
// memory read ports, runs the 64 rounds at one round per cycle with the
// schedule word for each round made in the cycle before, then does the
// chaining add. The round rate is set by the single-round datapath and the
// schedule memory, which serves w[t-15] and w[t-7] from its two read ports per
// round. While the digest drains, words that continue the same chain are
// already accepted; a word that starts a new message or ends a block waits
// until the drain is done.
module sha256_block_compress_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] msg_word
	input  logic        s_tuser,   // [0] new_message
	input  logic        s_tlast,   // final_block
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast    // last
);
	import sbc_pkg::*;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_PRIME = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]  state_q;
	logic [3:0]  word_cnt_q;
	logic [6:0]  cnt_q;
	logic        final_q;
	logic [2:0]  oidx_q;
	word_t       hv_q [HashWords];
	word_t       work_q [HashWords];
	word_t       k_s1;
	word_t       w_s1;

	logic        in_xfer;
	logic        out_xfer;
	logic [3:0]  eff_cnt;
	logic        blk_done;
	logic        cmp_en;
	word_t       t1;
	word_t       t2;
	sched_ctrl_t sched_ctrl;

	// A restart makes this word the first of the block.
	assign eff_cnt  = s_tuser ? 4'd0 : word_cnt_q;
	assign in_xfer  = s_tvalid && s_tready;
	assign blk_done = in_xfer && (eff_cnt == 4'hf);
	assign out_xfer = m_tvalid && m_tready;

	// During the digest drain take only words that neither touch the chaining
	// value nor close a block.
	assign s_tready = (state_q == ST_LOAD)
		|| ((state_q == ST_OUT) && !s_tuser && (word_cnt_q != 4'hf));

	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = hv_q[oidx_q];
	assign m_tuser  = oidx_q;
	assign m_tlast  = (oidx_q == 3'd7);

	// Schedule runs at cnt_q = t for t in 0..63; the round datapath takes its
	// registered word and constant in the next cycle, round t at cnt_q = t + 1.
	always_comb begin
		sched_ctrl.load_we   = in_xfer;
		sched_ctrl.load_addr = eff_cnt;
		sched_ctrl.load_data = s_tdata;
		sched_ctrl.rd_a_addr = (state_q == ST_PRIME) ? cnt_q[3:0] : cnt_q[3:0] + 4'd2;
		sched_ctrl.rd_b_addr = cnt_q[3:0] - 4'd6;
		sched_ctrl.step      = (state_q == ST_ROUND) && !cnt_q[6];
		sched_ctrl.expand    = (cnt_q[5:4] != 2'b00);
		sched_ctrl.wr_addr   = cnt_q[3:0];
	end

	sbc_sched u_sched (
		.clk  (clk),
		.ctrl (sched_ctrl),
		.w_s1 (w_s1)
	);

	assign cmp_en = (state_q == ST_ROUND) && (cnt_q != 7'd0);

	// One compression round on a..h held in work_q[0..7].
	always_comb begin
		t1 = work_q[7] + big_sig1(work_q[4])
			+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
			+ k_s1 + w_s1;
		t2 = big_sig0(work_q[0])
			+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			word_cnt_q <= 4'd0;
			cnt_q      <= 7'd0;
			final_q    <= 1'b0;
			oidx_q     <= 3'd0;
			hv_q       <= INIT_HV;
		end else begin
			if (in_xfer) begin
				word_cnt_q <= eff_cnt + 4'd1;
				if (s_tuser) begin
					hv_q <= INIT_HV;
				end
			end
			unique case (state_q)
				ST_LOAD: begin
					if (blk_done) begin
						final_q <= s_tlast;
						cnt_q   <= 7'd0;
						state_q <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					if (cnt_q[0]) begin
						cnt_q   <= 7'd0;
						state_q <= ST_ROUND;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_ROUND: begin
					if (cnt_q == 7'(NumRounds)) begin
						state_q <= ST_FIN;
					end
					cnt_q <= cnt_q + 7'd1;
				end
				ST_FIN: begin
					for (int i = 0; i < HashWords; i++) begin
						hv_q[i] <= hv_q[i] + work_q[i];
					end
					oidx_q  <= 3'd0;
					state_q <= final_q ? ST_OUT : ST_LOAD;
				end
				ST_OUT: begin
					if (out_xfer) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Working variables and round constant: payload, no reset.
	always_ff @(posedge clk) begin
		if ((state_q == ST_PRIME) && !cnt_q[0]) begin
			work_q <= hv_q;
		end else if (cmp_en) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
		if (sched_ctrl.step) begin
			k_s1 <= ROUND_K[cnt_q[5:0]];
		end
	end

`ifndef SYNTHESIS
	// A word load must never collide with a schedule write-back.
	a_no_mem_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(sched_ctrl.load_we && sched_ctrl.step))
		else $error("schedule memory write collision");

	// Closing a block starts the schedule priming.
	a_blk_starts: assert property (@(posedge clk) disable iff (!arst_n)
		blk_done && (state_q == ST_LOAD) |=> (state_q == ST_PRIME))
		else $error("block close did not start compression");

	// After the final round the chaining add follows directly.
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) && (cnt_q == 7'(NumRounds)) |=> (state_q == ST_FIN))
		else $error("round sequence overran");

	// The digest drain ends with the last word.
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && m_tlast |=> !m_tvalid)
		else $error("digest output continued past last word");
`endif

endmodule
